### rtl/srp_pkg.sv
// Package with shared types and constants of the skyline rectangle packer.
package srp_pkg;
  localparam int unsigned MaxPointsDefault = 64;
  localparam logic [15:0] AtlasWidthReset  = 16'd1024;
  localparam logic [15:0] AtlasHeightReset = 16'd1024;

  typedef enum logic [1:0] {
    StatOk   = 2'd0,
    StatNoFit = 2'd1,
    StatFull = 2'd2
  } status_e;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdClear  = 1'b1
  } command_e;

  typedef enum logic {
    RegAtlasWidth  = 1'b0,
    RegAtlasHeight = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CellHold     = 2'd0,
    CellTakePrev = 2'd1,
    CellTakeNext = 2'd2,
    CellLoad     = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] h;
  } point_t;
endpackage

### rtl/srp_if.sv
// Valid/ready channel interfaces for the packer's command and result words.
interface srp_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  modport source (output valid, command, rect_width, rect_height, input ready);
  modport sink   (input valid, command, rect_width, rect_height, output ready);
endinterface

interface srp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  modport source (output valid, status, pos_x, pos_y, input ready);
  modport sink   (input valid, status, pos_x, pos_y, output ready);
endinterface

### rtl/srp_cell.sv
// One skyline cell: holds a point and shifts it toward either neighbor.
module srp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srp_pkg::cell_op_e op_i,
  input  srp_pkg::point_t   prev_i,
  input  srp_pkg::point_t   next_i,
  input  srp_pkg::point_t   load_i,
  output srp_pkg::point_t   pt_o
);
  import srp_pkg::*;
  // The cell holds, takes its left or right neighbor, or loads a new point.
  point_t pt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
    end else begin
      unique case (op_i)
        CellHold:     pt_q <= pt_q;
        CellTakePrev: pt_q <= prev_i;
        CellTakeNext: pt_q <= next_i;
        CellLoad:     pt_q <= load_i;
      endcase
    end
  end
  assign pt_o = pt_q;
endmodule

### rtl/skyline_rect_packer_unit.sv
// Top level of the skyline rectangle packer: control, cell chain and APB registers.
//
// Channel | Dir | Word
// cmd     | in  | command, rect_width, rect_height
// res     | out | status, pos_x, pos_y
// apb     | in  | atlas_width (0x0), atlas_height (0x4)
//
// An insert visits each start point in SOuter, walks the points under each span in SInner,
// moves the tail through the cell chain one place at a time in SShift, writes the new
// points in SWrite and posts the result in SDone. A clear, or an insert refused because
// the chain is full, goes straight to SDone. Reset restores the single point (0,0).
// One item is in work at a time; a finished result waits in the output register while
// the next word is taken, and a stalled result only holds back the following result.
module skyline_rect_packer_unit #(
  parameter int unsigned MAX_POINTS = srp_pkg::MaxPointsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srp_cmd_if.sink     cmd,
  srp_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srp_pkg::*;
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    SIdle, SOuter, SInner, SShift, SWrite, SDone
  } state_e;

  logic [15:0] aw_q, ah_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= AtlasWidthReset;
      ah_q <= AtlasHeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegAtlasWidth)  aw_q <= pwdata[15:0];
      if (paddr[2] == RegAtlasHeight) ah_q <= pwdata[15:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegAtlasWidth) prdata[15:0] = aw_q;
    else                           prdata[15:0] = ah_q;
  end

  // Cell chain.
  cell_op_e    op   [MAX_POINTS];
  point_t      pts  [MAX_POINTS];
  point_t      ld   [MAX_POINTS];
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    point_t pv, nx;
    assign pv = (k == 0) ? pts[0] : pts[(k == 0) ? 0 : k - 1];
    assign nx = (k == MAX_POINTS - 1) ? pts[k] : pts[(k == MAX_POINTS - 1) ? k : k + 1];
    srp_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .op_i(op[k]),
      .prev_i(pv), .next_i(nx), .load_i(ld[k]), .pt_o(pts[k])
    );
  end

  state_e      state_q;
  logic [CW-1:0] n_q, i_q, j_q, lo_q, hi_q, dst_q, sh_q;
  logic [16:0] w_q, h_q;
  logic [16:0] xmax_q, py_q, by_q;
  logic [15:0] bx_q;
  logic [15:0] lh_q, brh_q;
  logic        found_q, addbr_q;
  logic [1:0]  wst_q;
  logic [15:0] wx_q, wy_q;
  logic [1:0]  st_q;
  logic [15:0] ox_q, oy_q;
  logic        ov_q;

  point_t pi, pj;
  assign pi  = pts[i_q[IW-1:0]];
  assign pj  = pts[j_q[IW-1:0]];

  assign cmd.ready = (state_q == SIdle);
  assign res.valid  = ov_q;
  assign res.status = st_q;
  assign res.pos_x  = ox_q;
  assign res.pos_y  = oy_q;

  logic [16:0] brx;
  assign brx = {1'b0, bx_q} + w_q;

  // Shift direction: grow moves tail right (from high index down), shrink left.
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      op[k] = CellHold;
      ld[k] = '0;
    end
    if (state_q == SIdle && cmd.valid && cmd.ready && cmd.command == CmdClear) begin
      op[0] = CellLoad;
    end else if (state_q == SShift && sh_q != '0) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (dst_q > hi_q && CW'(k) >= dst_q && CW'(k) < n_q + dst_q - hi_q) begin
          op[k] = CellTakePrev;
        end
        if (dst_q < hi_q && CW'(k) >= dst_q && CW'(k) < n_q) op[k] = CellTakeNext;
      end
    end else if (state_q == SWrite) begin
      op[lo_q[IW-1:0]] = CellLoad;
      ld[lo_q[IW-1:0]] = '{x: bx_q, h: 16'(by_q + h_q)};
      if (addbr_q) begin
        op[IW'(lo_q + CW'(1))] = CellLoad;
        ld[IW'(lo_q + CW'(1))] = '{x: brx[15:0], h: brh_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; n_q <= CW'(1); ov_q <= 1'b0;
      i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0; dst_q <= '0; sh_q <= '0;
      w_q <= '0; h_q <= '0; xmax_q <= '0; py_q <= '0; by_q <= '0; bx_q <= '0;
      lh_q <= '0; brh_q <= '0; wst_q <= StatOk; wx_q <= '0; wy_q <= '0;
      found_q <= 1'b0; addbr_q <= 1'b0; st_q <= StatOk; ox_q <= '0; oy_q <= '0;
    end else begin
      if (ov_q && res.ready && state_q != SDone) ov_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cmd.valid && cmd.ready) begin
            w_q <= {1'b0, cmd.rect_width} + 17'd1;
            h_q <= {1'b0, cmd.rect_height} + 17'd1;
            i_q <= '0; found_q <= 1'b0; by_q <= 17'd65535;
            wst_q <= StatOk; wx_q <= '0; wy_q <= '0;
            if (cmd.command == CmdClear) begin
              n_q <= CW'(1); state_q <= SDone;
            end else if (n_q >= CW'(MAX_POINTS)) begin
              wst_q <= StatFull; state_q <= SDone;
            end else begin
              state_q <= SOuter;
            end
          end
        end
        SOuter: begin
          if (i_q >= n_q || w_q > {1'b0, aw_q} - {1'b0, pi.x} || pi.x > aw_q) begin
            if (!found_q) begin
              wst_q <= StatNoFit; state_q <= SDone;
            end else begin
              state_q <= SShift;
            end
          end else if ({1'b0, pi.h} >= by_q) begin
            i_q <= i_q + CW'(1);
          end else begin
            py_q <= {1'b0, pi.h};
            lh_q <= pi.h;
            xmax_q <= {1'b0, pi.x} + w_q;
            j_q <= i_q + CW'(1);
            state_q <= SInner;
          end
        end
        SInner: begin
          if (j_q >= n_q || xmax_q <= {1'b0, pj.x}) begin
            if (!(py_q >= by_q || h_q > {1'b0, ah_q} - py_q || py_q > {1'b0, ah_q})) begin
              found_q <= 1'b1; lo_q <= i_q; hi_q <= j_q;
              bx_q <= pi.x; by_q <= py_q;
              // The trailing point keeps the height of the last covered point.
              brh_q <= lh_q;
              addbr_q <= (j_q < n_q) ? (xmax_q < {1'b0, pj.x}) : (xmax_q < {1'b0, aw_q});
            end
            i_q <= i_q + CW'(1);
            state_q <= SOuter;
          end else begin
            if ({1'b0, pj.h} > py_q) py_q <= {1'b0, pj.h};
            lh_q <= pj.h;
            j_q <= j_q + CW'(1);
          end
        end
        SShift: begin
          // dst computed once on entry via sh_q flag; shift one place per cycle.
          if (sh_q == '0 && dst_q != lo_q + CW'(1) + CW'(addbr_q)) begin
            dst_q <= lo_q + CW'(1) + CW'(addbr_q);
            sh_q <= CW'(1);
          end else if (dst_q == hi_q) begin
            sh_q <= '0;
            state_q <= SWrite;
          end else begin
            sh_q <= CW'(1);
            if (dst_q > hi_q) begin
              n_q <= n_q + CW'(1); hi_q <= hi_q + CW'(1);
            end else begin
              n_q <= n_q - CW'(1); hi_q <= hi_q - CW'(1);
            end
          end
        end
        SWrite: begin
          wx_q <= bx_q; wy_q <= by_q[15:0];
          dst_q <= '0;
          state_q <= SDone;
        end
        default: begin
          if (!ov_q || res.ready) begin
            ov_q <= 1'b1; st_q <= wst_q; ox_q <= wx_q; oy_q <= wy_q;
            state_q <= SIdle;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q >= CW'(1) && n_q <= CW'(MAX_POINTS)) else $error("point count out of range");
  a_nofit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q != StatOk) |-> (ox_q == '0 && oy_q == '0)) else $error("position on refusal");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !cmd.ready) else $error("ready while busy");
`endif
endmodule
